// File: sv/cng_pkg.sv
// Shared types and constants for the character n-gram tokenizer.
// No dependencies; every other file refers to this package by scoped names.
package cng_pkg;

  localparam int MAX_GRAM_CHARS = 10;
  localparam int MAX_CHAR_BYTES = 4;
  localparam int OFFSET_W       = 16;
  localparam int CHAR_W         = 3;
  localparam int IDX_W          = 4;
  localparam int CNT_W          = 4;
  localparam int SUM_W          = 6;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = 2;
  localparam int QCNT_W         = 3;

  localparam logic [3:0] NGRAM_LEN_RESET = 4'd3;

  // register indexes (paddr[2])
  localparam logic REG_NGRAM_LEN  = 1'b0;
  localparam logic REG_EMIT_SHORT = 1'b1;

  typedef enum logic [1:0] {
    KIND_INVALID = 2'd0,
    KIND_BLANK   = 2'd1,
    KIND_CHAR    = 2'd2
  } cng_kind_t;

  typedef struct packed {
    cng_kind_t           kind;
    logic [CHAR_W-1:0]   char_bytes;
    logic                last;
  } cng_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] ngram_len;    // already clamped to 1..MAX_GRAM_CHARS
    logic             emit_short;
    logic             ts_write;     // gram length written: empty the window
  } cng_cfg_t;

  typedef struct packed {
    logic                 is_short;
    logic [CNT_W-1:0]     gram_chars;
    logic [SUM_W-1:0]     gram_bytes;
    logic [OFFSET_W-1:0]  gram_offset;
  } cng_result_t;

endpackage

// File: sv/cng_front.sv
// Front end: accepts input items and classifies each character.
// Depends on cng_pkg.
module cng_front (
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [cng_pkg::CHAR_W-1:0] char_bytes,
  input  logic                    is_blank,
  input  logic                    last,
  input  logic                    queue_full,
  output logic                    push,
  output cng_pkg::cng_item_t      item
);

  assign s_tready = !queue_full;
  assign push     = s_tvalid && !queue_full;

  always_comb begin
    item.char_bytes = char_bytes;
    item.last       = last;
    if (char_bytes == '0 ||
        char_bytes > cng_pkg::CHAR_W'(cng_pkg::MAX_CHAR_BYTES)) begin
      item.kind = cng_pkg::KIND_INVALID;
    end else if (is_blank && char_bytes == cng_pkg::CHAR_W'(1)) begin
      item.kind = cng_pkg::KIND_BLANK;
    end else begin
      item.kind = cng_pkg::KIND_CHAR;
    end
  end

endmodule

// File: sv/cng_queue.sv
// Short queue of classified items between front and back end.
// Depends on cng_pkg.
module cng_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  cng_pkg::cng_item_t push_item,
  input  logic               pop,
  output cng_pkg::cng_item_t pop_item,
  output logic               full,
  output logic               empty
);

  cng_pkg::cng_item_t entries [cng_pkg::QUEUE_DEPTH];
  logic [cng_pkg::QPTR_W-1:0] wr_ptr;
  logic [cng_pkg::QPTR_W-1:0] rd_ptr;
  logic [cng_pkg::QCNT_W-1:0] count;

  assign full     = (count == cng_pkg::QCNT_W'(cng_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/cng_back.sv
// Back end: sliding window of character lengths, gram emission and the
// registered output stage. Depends on cng_pkg.
module cng_back (
  input  logic                clk,
  input  logic                rst,
  input  cng_pkg::cng_cfg_t   cfg,
  input  logic                queue_empty,
  input  cng_pkg::cng_item_t  item,
  output logic                pop,
  output logic                m_valid,
  input  logic                m_ready,
  output cng_pkg::cng_result_t result
);

  localparam int OW = cng_pkg::OFFSET_W;
  localparam int IW = cng_pkg::IDX_W;
  localparam int CW = cng_pkg::CNT_W;
  localparam int SW = cng_pkg::SUM_W;

  logic [cng_pkg::CHAR_W-1:0] window [cng_pkg::MAX_GRAM_CHARS];
  logic [IW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [SW-1:0] win_sum, win_sum_next;
  logic [OW-1:0] gram_start, gram_start_next;
  logic [OW-1:0] scan_pos, scan_pos_next;
  logic          none_emitted, none_emitted_next;
  logic          stopped, stopped_next;

  logic                 wr_en;
  logic [IW-1:0]        tail;
  logic [IW:0]          tail_raw;
  logic [CW-1:0]        cnt1;
  logic [SW-1:0]        sum1;
  logic [cng_pkg::CHAR_W-1:0] oldest;
  logic                 emit;
  logic                 emit_short_gram;
  cng_pkg::cng_result_t res_next;

  function automatic logic [OW-1:0] sat_add(input logic [OW-1:0] a,
                                            input logic [cng_pkg::CHAR_W-1:0] b);
    logic [OW:0] s;
    s = {1'b0, a} + (OW+1)'(b);
    return s[OW] ? '1 : s[OW-1:0];
  endfunction

  assign pop = !queue_empty && (!m_valid || m_ready);

  always_comb begin
    tail_raw = {1'b0, head} + {1'b0, count};
    if (tail_raw >= (IW+1)'(cng_pkg::MAX_GRAM_CHARS)) begin
      tail = IW'(tail_raw - (IW+1)'(cng_pkg::MAX_GRAM_CHARS));
    end else begin
      tail = tail_raw[IW-1:0];
    end
    cnt1   = count + 1'b1;
    sum1   = win_sum + SW'(item.char_bytes);
    oldest = (count == '0) ? item.char_bytes : window[head];
  end

  always_comb begin
    head_next         = head;
    count_next        = count;
    win_sum_next      = win_sum;
    gram_start_next   = gram_start;
    scan_pos_next     = scan_pos;
    none_emitted_next = none_emitted;
    stopped_next      = stopped;
    wr_en             = 1'b0;
    emit              = 1'b0;
    emit_short_gram   = 1'b0;
    res_next.gram_offset = gram_start;
    res_next.gram_bytes  = sum1;
    res_next.gram_chars  = cnt1;
    res_next.is_short    = 1'b0;

    if (!stopped) begin
      case (item.kind)
        cng_pkg::KIND_INVALID: begin
          stopped_next = 1'b1;
        end
        cng_pkg::KIND_BLANK: begin
          scan_pos_next   = sat_add(scan_pos, cng_pkg::CHAR_W'(1));
          gram_start_next = scan_pos_next;
          head_next       = '0;
          count_next      = '0;
          win_sum_next    = '0;
        end
        cng_pkg::KIND_CHAR: begin
          wr_en         = 1'b1;
          scan_pos_next = sat_add(scan_pos, item.char_bytes);
          if (cnt1 >= cfg.ngram_len) begin
            emit              = 1'b1;
            gram_start_next   = sat_add(gram_start, oldest);
            head_next         = (head == IW'(cng_pkg::MAX_GRAM_CHARS - 1)) ? '0 : head + 1'b1;
            count_next        = count;
            win_sum_next      = sum1 - SW'(oldest);
            none_emitted_next = 1'b0;
          end else begin
            count_next   = cnt1;
            win_sum_next = sum1;
          end
        end
        default: begin
          stopped_next = stopped;
        end
      endcase
    end

    if (item.last) begin
      if (!emit && cfg.emit_short && count_next != '0 && none_emitted) begin
        emit_short_gram      = 1'b1;
        res_next.gram_offset = gram_start_next;
        res_next.gram_bytes  = win_sum_next;
        res_next.gram_chars  = count_next;
        res_next.is_short    = 1'b1;
      end
      head_next         = '0;
      count_next        = '0;
      win_sum_next      = '0;
      gram_start_next   = '0;
      scan_pos_next     = '0;
      none_emitted_next = 1'b1;
      stopped_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && wr_en) begin
      window[tail] <= item.char_bytes;
    end
    if (pop) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head         <= '0;
      count        <= '0;
      win_sum      <= '0;
      gram_start   <= '0;
      scan_pos     <= '0;
      none_emitted <= 1'b1;
      stopped      <= 1'b0;
      m_valid      <= 1'b0;
    end else begin
      if (cfg.ts_write) begin
        head       <= '0;
        count      <= '0;
        win_sum    <= '0;
        gram_start <= scan_pos;
      end else if (pop) begin
        head         <= head_next;
        count        <= count_next;
        win_sum      <= win_sum_next;
        gram_start   <= gram_start_next;
        scan_pos     <= scan_pos_next;
        none_emitted <= none_emitted_next;
        stopped      <= stopped_next;
      end
      if (pop) begin
        m_valid <= emit || emit_short_gram;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/character_ngram_tokenizer.sv
// Character n-gram tokenizer, top level: register port, front end, queue and
// back end. Depends on cng_pkg, cng_front, cng_queue and cng_back.
//
// One decoded character is taken per cycle while the queue is not full, and
// each full n-gram of the configured gram length comes out as byte offset,
// byte length and character count; a blank empties the window, an invalid
// length ignores the rest of the document, and with emit_short set a
// document that produced no full gram ends with its leftover short gram if
// the window is not empty. The sustained rate is one item per clock while
// the result side is not stalled, as the back end's window update is
// combinational. A result item passes through the queue and the registered
// output stage. A four-item queue between classifier and window logic keeps
// the input flowing for up to four items while the result side is stalled.
// Write the registers only while the block is idle: writing the gram length
// empties the window, and the next gram starts at the current scan position.
module character_ngram_tokenizer (
  input  logic        clk,
  input  logic        rst,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [2:0] char_bytes, rest zero
  input  logic        s_tuser,   // [0] is_blank
  input  logic        s_tlast,   // last character of the document
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] gram_offset, [21:16] gram_bytes,
                                 // [25:22] gram_chars, rest zero
  output logic        m_tuser    // [0] is_short
);

  logic [3:0]           ngram_len;
  logic                 emit_short;
  logic                 cfg_write;
  cng_pkg::cng_cfg_t    cfg;
  cng_pkg::cng_item_t   front_item;
  cng_pkg::cng_item_t   back_item;
  cng_pkg::cng_result_t result;
  logic                 push;
  logic                 pop;
  logic                 queue_full;
  logic                 queue_empty;

  // Registers: address decoded on paddr[2], always ready.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ngram_len  <= cng_pkg::NGRAM_LEN_RESET;
      emit_short <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[2])
        cng_pkg::REG_NGRAM_LEN:  ngram_len  <= pwdata[3:0];
        cng_pkg::REG_EMIT_SHORT: emit_short <= pwdata[0];
        default:                 ngram_len  <= ngram_len;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      cng_pkg::REG_NGRAM_LEN:  prdata = {28'd0, ngram_len};
      cng_pkg::REG_EMIT_SHORT: prdata = {31'd0, emit_short};
      default:                 prdata = '0;
    endcase
  end

  // Clamp gram length to 1..MAX_GRAM_CHARS once, here.
  always_comb begin
    if (ngram_len == '0) begin
      cfg.ngram_len = cng_pkg::CNT_W'(1);
    end else if (ngram_len > cng_pkg::CNT_W'(cng_pkg::MAX_GRAM_CHARS)) begin
      cfg.ngram_len = cng_pkg::CNT_W'(cng_pkg::MAX_GRAM_CHARS);
    end else begin
      cfg.ngram_len = ngram_len;
    end
    cfg.emit_short = emit_short;
    cfg.ts_write   = cfg_write && (paddr[2] == cng_pkg::REG_NGRAM_LEN);
  end

  cng_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .char_bytes (s_tdata[2:0]),
    .is_blank   (s_tuser),
    .last       (s_tlast),
    .queue_full (queue_full),
    .push       (push),
    .item       (front_item)
  );

  // Hold classified items until the window logic takes them.
  cng_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .pop_item  (back_item),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  cng_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .queue_empty (queue_empty),
    .item        (back_item),
    .pop         (pop),
    .m_valid     (m_tvalid),
    .m_ready     (m_tready),
    .result      (result)
  );

  assign m_tdata = {6'd0, result.gram_chars, result.gram_bytes, result.gram_offset};
  assign m_tuser = result.is_short;

endmodule
